// File: rtl/laplf_pkg.sv
// Shared constants and types for the Laplacian 5x5 RGB filter.
`default_nettype none
package laplf_pkg;

  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int WINDOW_SIZE_DEF = 5;

  localparam int PIX_W      = 8;
  localparam int RGB_W      = 3 * PIX_W;
  localparam int IMG_W_BITS = 12;
  localparam int IMG_H_BITS = 13;
  localparam int ROW_W      = 13;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [IMG_H_BITS-1:0] HEIGHT_RESET = 13'd480;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_t;

endpackage
`default_nettype wire

// File: rtl/laplacian_5x5_rgb_filter.sv
// Streaming Laplacian edge filter on RGB pixels with a column-history line memory.
//
//  Channel   | Dir | Content
//  s_axis_*  | in  | pixels and drain items, tuser = opcode
//  m_axis_*  | out | filtered pixels in raster order, tlast = last of frame
//  APB       | cfg | image_width at 0x0, image_height at 0x4
//
// One item per clock outside the stalls below; results pass the stage and output registers.
// The line memory is read and written back once per item on a single port
// pair, which sets the one-item-per-clock figure.
// Reset clears control state only; the line memory needs no clearing pass.
// A two-entry output stage lets input continue while a result waits; input
// stalls while the skid entry is full, and after the last pixel of a frame
// with fewer pixels than the output delay, until padding covers the pixels missing.
`default_nettype none
module laplacian_5x5_rgb_filter #(
  parameter int MAX_WIDTH   = laplf_pkg::MAX_WIDTH_DEF,
  parameter int WINDOW_SIZE = laplf_pkg::WINDOW_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [laplf_pkg::RGB_W-1:0]   s_axis_tdata,  // in_red, in_green, in_blue
  input  wire logic                          s_axis_tuser,  // opcode
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [laplf_pkg::RGB_W-1:0]        m_axis_tdata,  // out_red, out_green, out_blue
  output logic                               m_axis_tlast,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [laplf_pkg::PADDR_W-1:0] paddr,
  input  wire logic [laplf_pkg::PDATA_W-1:0] pwdata,
  output logic [laplf_pkg::PDATA_W-1:0]      prdata,
  output logic                               pready
);
  import laplf_pkg::*;

  localparam int K     = WINDOW_SIZE / 2;
  localparam int NV    = 2 * K + 1;
  localparam int NM    = 2 * K;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int DW    = $clog2(K * MAX_WIDTH + K + 1);
  localparam int MEM_W = NM * RGB_W;
  localparam int CS_W  = $clog2(WINDOW_SIZE * 255 + 1);
  localparam int TOT_W = $clog2(WINDOW_SIZE * WINDOW_SIZE * 255 + 1);
  localparam int XW    = CW + 2;

  // configuration
  logic [IMG_W_BITS-1:0] image_width;
  logic [IMG_H_BITS-1:0] image_height;
  logic                  cfg_wr;
  reg_index_t            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_index_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH:  image_width  <= pwdata[IMG_W_BITS-1:0];
        REG_HEIGHT: image_height <= pwdata[IMG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  prdata = PDATA_W'(image_width);
      REG_HEIGHT: prdata = PDATA_W'(image_height);
      default:    prdata = '0;
    endcase
  end

  // frame control state
  logic                  busy, busy_next;
  logic                  done, done_next;
  logic [CW-1:0]         in_col, in_col_next;
  logic [ROW_W-1:0]      in_row, in_row_next;
  logic [CW-1:0]         oc, oc_next;
  logic [ROW_W-1:0]      orow, orow_next;
  logic [WW-1:0]         fw, fw_next;
  logic [IMG_H_BITS-1:0] fh, fh_next;
  logic [DW-1:0]         delay, delay_next;
  logic [DW-1:0]         lead, lead_next;

  logic                  adv, accept, is_drain, start, act, emit_cur, last_cur;
  logic                  pad_active, pad_go, step;
  logic [CW-1:0]         cur_col, cur_oc;
  logic [ROW_W-1:0]      cur_row, cur_orow;
  logic [WW-1:0]         cur_fw;
  logic [IMG_H_BITS-1:0] cur_fh;
  logic [DW-1:0]         cur_delay, cur_lead;
  logic [13:0]           iw_ext;

  // after the last pixel of a short frame, push empty columns until the
  // output delay is covered, so each drain sees its full window
  assign pad_active    = busy && done && (lead < delay);
  assign pad_go        = pad_active && adv;
  assign s_axis_tready = adv && !pad_active;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign is_drain = (opcode_t'(s_axis_tuser) == OP_DRAIN);
  assign start    = !pad_active && !is_drain && (!busy || done);
  assign act      = !is_drain || (busy && done);
  assign step     = (accept && act) || pad_go;
  assign iw_ext   = 14'(image_width);

  always_comb begin
    if (start) begin
      if (image_width == '0)              cur_fw = WW'(1);
      else if (iw_ext > 14'(MAX_WIDTH))   cur_fw = WW'(MAX_WIDTH);
      else                                cur_fw = WW'(image_width);
      if (image_height == '0)                         cur_fh = IMG_H_BITS'(1);
      else if (image_height > IMG_H_BITS'(MAX_HEIGHT)) cur_fh = IMG_H_BITS'(MAX_HEIGHT);
      else                                            cur_fh = image_height;
      cur_delay = DW'(cur_fw) * DW'(K) + DW'(K);
      cur_col   = '0;
      cur_row   = '0;
      cur_oc    = '0;
      cur_orow  = '0;
      cur_lead  = '0;
    end else begin
      cur_fw    = fw;
      cur_fh    = fh;
      cur_delay = delay;
      cur_col   = in_col;
      cur_row   = in_row;
      cur_oc    = oc;
      cur_orow  = orow;
      cur_lead  = lead;
    end
    emit_cur = !pad_active && (is_drain || (cur_lead >= cur_delay));
    last_cur = (cur_orow + ROW_W'(1) == ROW_W'(cur_fh)) && (WW'(cur_oc) + WW'(1) == cur_fw);
  end

  always_comb begin
    busy_next   = busy;
    done_next   = done;
    in_col_next = in_col;
    in_row_next = in_row;
    oc_next     = oc;
    orow_next   = orow;
    fw_next     = fw;
    fh_next     = fh;
    delay_next  = delay;
    lead_next   = lead;
    if (step) begin
      fw_next    = cur_fw;
      fh_next    = cur_fh;
      delay_next = cur_delay;
      busy_next  = 1'b1;
      done_next  = start ? 1'b0 : done;
      if (WW'(cur_col) + WW'(1) == cur_fw) begin
        in_col_next = '0;
        in_row_next = cur_row + ROW_W'(1);
        if (!is_drain && (cur_row + ROW_W'(1) == ROW_W'(cur_fh))) done_next = 1'b1;
      end else begin
        in_col_next = cur_col + CW'(1);
        in_row_next = cur_row;
      end
      lead_next = ((pad_active || !is_drain) && (cur_lead < cur_delay)) ?
                  cur_lead + DW'(1) : cur_lead;
      oc_next   = cur_oc;
      orow_next = cur_orow;
      if (emit_cur) begin
        if (WW'(cur_oc) + WW'(1) == cur_fw) begin
          oc_next   = '0;
          orow_next = cur_orow + ROW_W'(1);
        end else begin
          oc_next = cur_oc + CW'(1);
        end
        if (last_cur) busy_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      in_col <= '0;
      in_row <= '0;
      oc     <= '0;
      orow   <= '0;
      fw     <= WW'(640);
      fh     <= IMG_H_BITS'(480);
      delay  <= '0;
      lead   <= '0;
    end else begin
      busy   <= busy_next;
      done   <= done_next;
      in_col <= in_col_next;
      in_row <= in_row_next;
      oc     <= oc_next;
      orow   <= orow_next;
      fw     <= fw_next;
      fh     <= fh_next;
      delay  <= delay_next;
      lead   <= lead_next;
    end
  end

  // stage 1: line memory read, masking, write back
  logic [MEM_W-1:0]  mem [MAX_WIDTH];
  logic [MEM_W-1:0]  rdata;
  logic              s1_valid, s1_emit, s1_last, s1_fwd;
  logic [CW-1:0]     s1_addr, s1_oc;
  logic [ROW_W-1:0]  s1_row;
  logic [WW-1:0]     s1_fw;
  logic [RGB_W-1:0]  s1_data;
  logic [MEM_W-1:0]  s1_fwd_data, old_col, wb;
  logic [RGB_W-1:0]  vcol [NV];
  logic              mem_re, mem_we;

  assign mem_re = step;
  assign mem_we = adv && s1_valid;

  always_ff @(posedge clk) begin
    if (mem_we) mem[s1_addr] <= wb;
    if (mem_re) rdata <= mem[cur_col];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      s1_addr     <= cur_col;
      s1_row      <= cur_row;
      s1_data     <= (is_drain || pad_active) ? '0 : s_axis_tdata;
      s1_emit     <= emit_cur;
      s1_last     <= last_cur;
      s1_oc       <= cur_oc;
      s1_fw       <= cur_fw;
      // same column written back this cycle: take the new history instead
      s1_fwd      <= s1_valid && (s1_addr == cur_col);
      s1_fwd_data <= wb;
    end
  end

  always_comb begin
    old_col = s1_fwd ? s1_fwd_data : rdata;
    for (int j = 0; j < NM; j++) begin
      vcol[j] = (s1_row < ROW_W'(NM - j)) ? '0 : old_col[j*RGB_W +: RGB_W];
    end
    vcol[NM] = s1_data;
    for (int j = 0; j < NM; j++) begin
      wb[j*RGB_W +: RGB_W] = vcol[j+1];
    end
  end

  // window: slot NV-1 holds the newest column
  logic [RGB_W-1:0] win [NV][NV];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int a = 0; a < NV - 1; a++) begin
        for (int j = 0; j < NV; j++) win[a][j] <= win[a+1][j];
      end
      for (int j = 0; j < NV; j++) win[NV-1][j] <= vcol[j];
    end
  end

  // stage 2: masked column sums
  logic             s2_valid, s2_last;
  logic [CW-1:0]    s2_oc;
  logic [WW-1:0]    s2_fw;
  logic [CS_W-1:0]  colsum [WINDOW_SIZE][3];
  logic [XW-1:0]    xk [WINDOW_SIZE];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_oc   <= s1_oc;
      s2_fw   <= s1_fw;
      s2_last <= s1_last;
    end
  end

  always_comb begin
    for (int a = 0; a < WINDOW_SIZE; a++) begin
      xk[a] = XW'(s2_oc) + XW'(a);
      for (int ch = 0; ch < 3; ch++) begin
        colsum[a][ch] = '0;
        if ((xk[a] >= XW'(K)) && (xk[a] - XW'(K) < XW'(s2_fw))) begin
          for (int j = 0; j < WINDOW_SIZE; j++) begin
            colsum[a][ch] = colsum[a][ch] + CS_W'(win[a][j][ch*PIX_W +: PIX_W]);
          end
        end
      end
    end
  end

  // stage 3: total, center weight, clamp
  logic                    s3_valid, s3_last;
  logic [CS_W-1:0]         s3_colsum [WINDOW_SIZE][3];
  logic [RGB_W-1:0]        s3_ctr;
  logic [TOT_W-1:0]        tot [3];
  logic [TOT_W-1:0]        ctr_w [3];
  logic signed [TOT_W:0]   diff [3];
  logic [RGB_W-1:0]        res;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_colsum <= colsum;
      s3_ctr    <= win[K][K];
      s3_last   <= s2_last;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tot[ch] = '0;
      for (int a = 0; a < WINDOW_SIZE; a++) tot[ch] = tot[ch] + TOT_W'(s3_colsum[a][ch]);
      ctr_w[ch] = TOT_W'(s3_ctr[ch*PIX_W +: PIX_W]) * TOT_W'(WINDOW_SIZE * WINDOW_SIZE);
      diff[ch]  = $signed({1'b0, ctr_w[ch]}) - $signed({1'b0, tot[ch]});
      if (diff[ch] < 0)                          res[ch*PIX_W +: PIX_W] = '0;
      else if (diff[ch] > (TOT_W+1)'(255))       res[ch*PIX_W +: PIX_W] = 8'hFF;
      else                                       res[ch*PIX_W +: PIX_W] = diff[ch][PIX_W-1:0];
    end
  end

  // output register with skid entry
  logic             skid_valid, skid_last;
  logic [RGB_W-1:0] skid_data;

  assign adv = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (m_axis_tready || !m_axis_tvalid) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        m_axis_tvalid <= s3_valid;
      end
    end else if (s3_valid && adv) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !m_axis_tvalid) begin
      if (skid_valid) begin
        m_axis_tdata <= skid_data;
        m_axis_tlast <= skid_last;
      end else begin
        m_axis_tdata <= res;
        m_axis_tlast <= s3_last;
      end
    end else if (s3_valid && adv) begin
      skid_data <= res;
      skid_last <= s3_last;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid entry holds data while output is empty");

  a_lead_bounded: assert property (@(posedge clk) disable iff (rst)
    lead <= delay)
    else $error("pixel lead counter ran past the output delay");

  a_out_col_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (WW'(oc) < fw))
    else $error("output column outside the frame");

  a_fwd_same_col: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_fwd) |-> (s1_addr == $past(s1_addr)))
    else $error("forwarded history taken for a different column");

endmodule
`default_nettype wire

// File: sim/laplacian_5x5_rgb_filter_tb.sv
// Self-checking testbench for the streaming 5x5 Laplacian RGB edge filter.
`timescale 1ns / 100ps
module laplacian_5x5_rgb_filter_tb;
  import laplf_pkg::*;

  localparam int WDOG_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_ITEMS = 840;
  localparam int KOFF         = WINDOW_SIZE_DEF / 2;
  localparam int STORE_ROWS   = 2 * WINDOW_SIZE_DEF;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } edge_pixel_t;

  class edge_scoreboard;
    logic [RGB_W-1:0] pix_rows [STORE_ROWS][MAX_WIDTH_DEF];
    int cfg_w = 640, cfg_h = 480, fw = 640, fh = 480;
    int in_col, in_row, out_col, out_row;
    bit busy;
    int errors, results_seen;
    edge_pixel_t pending[$];

    function void write_reg(reg_index_t idx, logic [PDATA_W-1:0] v);
      if (idx == REG_WIDTH) cfg_w = int'(v[IMG_W_BITS-1:0]);
      else cfg_h = int'(v[IMG_H_BITS-1:0]);
    endfunction

    function int clamp_size(int v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int clamp_byte(int v);
      if (v < 0) return 0;
      if (v > 255) return 255;
      return v;
    endfunction

    // Filter the pixel at the output position and advance it.
    function void filter_next();
      int acc [3];
      int y, x, wt;
      logic [RGB_W-1:0] px;
      edge_pixel_t res;
      acc = '{0, 0, 0};
      for (int dy = -KOFF; dy < WINDOW_SIZE_DEF - KOFF; dy++) begin
        y = out_row + dy;
        if (y < 0 || y >= fh) continue;
        for (int dx = -KOFF; dx < WINDOW_SIZE_DEF - KOFF; dx++) begin
          x = out_col + dx;
          if (x < 0 || x >= fw) continue;
          wt = (dy == 0 && dx == 0) ? WINDOW_SIZE_DEF * WINDOW_SIZE_DEF - 1 : -1;
          px = pix_rows[y % STORE_ROWS][x % MAX_WIDTH_DEF];
          for (int ch = 0; ch < 3; ch++) acc[ch] += int'(px[8*ch +: 8]) * wt;
        end
      end
      res.red   = 8'(clamp_byte(acc[0]));
      res.green = 8'(clamp_byte(acc[1]));
      res.blue  = 8'(clamp_byte(acc[2]));
      res.last  = (out_row == fh - 1) && (out_col == fw - 1);
      pending.push_back(res);
      out_col++;
      if (out_col >= fw) begin
        out_col = 0;
        out_row++;
      end
      if (res.last) busy = 0;
    endfunction

    function void note_input(opcode_t op, logic [RGB_W-1:0] d);
      int pos;
      if (op == OP_DRAIN) begin
        if (busy && in_row >= fh) filter_next();
        return;
      end
      if (!busy || in_row >= fh) begin
        fw = clamp_size(cfg_w, MAX_WIDTH_DEF);
        fh = clamp_size(cfg_h, MAX_HEIGHT);
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        busy = 1;
      end
      pix_rows[in_row % STORE_ROWS][in_col % MAX_WIDTH_DEF] = d;
      pos = in_row * fw + in_col;
      in_col++;
      if (in_col >= fw) begin
        in_col = 0;
        in_row++;
      end
      if (pos >= KOFF * fw + KOFF) filter_next();
    endfunction

    function void check_result(logic [RGB_W-1:0] d, logic last);
      edge_pixel_t exp_px;
      results_seen++;
      if (pending.size() == 0) begin
        $error("unexpected result tdata=%h tlast=%b", d, last);
        errors++;
        return;
      end
      exp_px = pending.pop_front();
      if (d[7:0] !== exp_px.red) begin
        $error("out_red expected %0d actual %0d", exp_px.red, d[7:0]); errors++;
      end
      if (d[15:8] !== exp_px.green) begin
        $error("out_green expected %0d actual %0d", exp_px.green, d[15:8]); errors++;
      end
      if (d[23:16] !== exp_px.blue) begin
        $error("out_blue expected %0d actual %0d", exp_px.blue, d[23:16]); errors++;
      end
      if (last !== exp_px.last) begin
        $error("frame_last expected %0b actual %0b", exp_px.last, last); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [RGB_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid, m_axis_tready = 0, m_axis_tlast;
  logic [RGB_W-1:0] m_axis_tdata;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0, prdata;
  logic pready;

  edge_scoreboard sb = new();
  bit quiet = 0;
  int items_sent = 0, frames_sent = 0;
  int stall_left = 0, idle_cycles = 0;

  laplacian_5x5_rgb_filter i_dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial forever #10 clk = ~clk;

  // Result side: check transfers, stall in bursts, watch for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
    if (stall_left > 0) begin
      m_axis_tready <= 0;
      stall_left--;
    end else begin
      m_axis_tready <= 1;
      if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 9);
    end
  end

  task automatic send_item(opcode_t op, logic [RGB_W-1:0] d);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= d;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(op, d);
    items_sent++;
  endtask

  task automatic apb_write(reg_index_t idx, logic [PDATA_W-1:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= PADDR_W'(int'(idx) * 4); pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.write_reg(idx, v);
  endtask

  // Wait until the block is drained, then program the frame size.
  task automatic set_size(int w, int h);
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
  endtask

  function automatic logic [7:0] pick_channel(bit harsh);
    if (harsh && $urandom_range(0, 1)) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Send one frame; drain fully, or cut the drain short so the next frame drops it.
  task automatic send_frame(int w, int h, bit full_drain, bit harsh, bit noise);
    int fw, fh, left, n;
    fw = sb.clamp_size(w, MAX_WIDTH_DEF);
    fh = sb.clamp_size(h, MAX_HEIGHT);
    for (int i = 0; i < fw * fh; i++) begin
      if (noise && $urandom_range(0, 11) == 0) send_item(OP_DRAIN, RGB_W'($urandom));
      send_item(OP_PIXEL, {pick_channel(harsh), pick_channel(harsh), pick_channel(harsh)});
    end
    left = (KOFF * fw + KOFF < fw * fh) ? KOFF * fw + KOFF : fw * fh;
    n = full_drain ? left + $urandom_range(0, 2) : $urandom_range(0, left - 1);
    repeat (n) send_item(OP_DRAIN, RGB_W'($urandom));
    frames_sent++;
  endtask

  initial begin
    int w, h, nframes, target;
    repeat (12) @(posedge clk);
    rst <= 0;

    // Directed: early drains, saturated pixels, drop of pending results, size clamps.
    set_size(4, 4);
    send_item(OP_DRAIN, 24'hFFFFFF);
    send_item(OP_DRAIN, 24'h000000);
    for (int i = 0; i < 16; i++)
      send_item(OP_PIXEL, (i == 5 || i == 10) ? 24'hFFFFFF :
                          (i % 3 == 0) ? 24'h00FF00 : 24'hFF00FF);
    repeat (11) send_item(OP_DRAIN, 24'hFFFFFF);
    set_size(3, 2);
    send_frame(3, 2, 0, 1, 0);
    send_frame(3, 2, 1, 1, 0);
    set_size(1, 1);
    send_frame(1, 1, 1, 1, 0);
    set_size(0, 0);
    send_frame(0, 0, 1, 1, 0);

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if (items_sent > target - 150) quiet = 1;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 8);
      set_size(w, h);
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++)
        send_frame(w, h, (f == nframes - 1) || $urandom_range(0, 1),
                   $urandom_range(0, 1), 1);
    end

    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d items in %0d frames, %0d results checked",
             items_sent, frames_sent, sb.results_seen);
    $display("frame sizes from 1x1 up to 24x12, zero sizes clamped to one");
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: files.f
rtl/laplf_pkg.sv
rtl/laplacian_5x5_rgb_filter.sv
sim/laplacian_5x5_rgb_filter_tb.sv
